### rtl/core/sdq_pkg.sv
// Shared command codes, datapath operation codes and control structs for the searchable deque.
package sdq_pkg;

    // Command codes carried on s_command.
    localparam logic [3:0] CMD_ADD_TAIL = 4'd0;
    localparam logic [3:0] CMD_ADD_HEAD = 4'd1;
    localparam logic [3:0] CMD_REMOVE   = 4'd2;
    localparam logic [3:0] CMD_POP_HEAD = 4'd3;
    localparam logic [3:0] CMD_POP_TAIL = 4'd4;
    localparam logic [3:0] CMD_CONTAINS = 4'd5;
    localparam logic [3:0] CMD_FIRST    = 4'd6;
    localparam logic [3:0] CMD_NEXT     = 4'd7;
    localparam logic [3:0] CMD_CLEAR    = 4'd8;

    localparam int CMD_W   = 4;
    localparam int HOUT_W  = 32;
    localparam int COUNT_W = 7;

    // Operations the controller asks of the datapath.
    localparam logic [2:0] OP_IDLE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_SHUP   = 3'd3;
    localparam logic [2:0] OP_SHDN   = 3'd4;
    localparam logic [2:0] OP_FINISH = 3'd5;

    typedef struct packed {
        logic [2:0] op;
    } sdq_cmd_t;

    typedef struct packed {
        logic cmd_done;
        logic scan_done;
        logic shift_done;
    } sdq_stat_t;

endpackage

### rtl/core/sdq_ctrl.sv
// Controller state machine sequencing each command through the datapath.
module sdq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              m_valid,
    input  logic              m_ready,
    input  sdq_pkg::sdq_stat_t stat,
    output sdq_pkg::sdq_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_SHUP   = 3'd4;

    logic [2:0] state_reg, state_next;

    // A new beat is taken only when the output register is empty or its result is taken in the same cycle.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid || m_ready);

    // Next state and datapath operation.
    always_comb begin
        state_next = state_reg;
        cmd.op     = sdq_pkg::OP_IDLE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.op     = sdq_pkg::OP_LOAD;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.op = sdq_pkg::OP_SEARCH;
                if (stat.scan_done) begin
                    state_next = stat.cmd_done ? ST_FINISH : ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                cmd.op = sdq_pkg::OP_SHDN;
                if (stat.shift_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHUP: begin
                cmd.op = sdq_pkg::OP_SHUP;
                if (stat.shift_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.op     = sdq_pkg::OP_FINISH;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        // Add at head shifts up rather than down.
        if (state_reg == ST_SEARCH && stat.scan_done && !stat.cmd_done && stat.shift_done) begin
            state_next = ST_SHUP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/sdq_datapath.sv
// Datapath: entry memory, search and shift walker, count and cursor registers.
module sdq_datapath #(
    parameter int DEPTH        = 64,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [sdq_pkg::CMD_W-1:0]     s_command,
    input  logic [31:0]                   s_handle,
    input  sdq_pkg::sdq_cmd_t             cmd,
    output sdq_pkg::sdq_stat_t            stat,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic                          m_ok,
    output logic [sdq_pkg::HOUT_W-1:0]    m_handle_out,
    output logic [sdq_pkg::COUNT_W-1:0]   m_count,
    output logic                          m_is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;           // count width, holds DEPTH
    localparam int KW = AW + 1;           // cursor width, up to 2*DEPTH-1
    localparam logic [KW-1:0] CURSOR_MAX = KW'(2 * DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C    = CW'(DEPTH);

    logic [HANDLE_WIDTH-1:0] mem [DEPTH];
    logic [HANDLE_WIDTH-1:0] rd_data_reg;

    logic [sdq_pkg::CMD_W-1:0] op_reg;
    logic [HANDLE_WIDTH-1:0]   key_reg;
    logic [CW-1:0]             count_reg, count_next;
    logic [KW-1:0]             cursor_reg, cursor_next;
    logic [CW-1:0]             idx_reg, idx_next;     // walker index
    logic                      rd_pend_reg;           // read data valid (for idx-1 while searching)
    logic [CW-1:0]             pos_reg, pos_next;     // found position
    logic                      found_reg, found_next;
    logic                      ok_reg, ok_next;
    logic [HANDLE_WIDTH-1:0]   hout_reg, hout_next;
    logic                      m_valid_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [HANDLE_WIDTH-1:0] wr_data;
    logic [HANDLE_WIDTH-1:0] key_in;

    assign key_in = HANDLE_WIDTH'(s_handle);

    // Memory with one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Search, single-read and shift sequencing.
    always_comb begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        ok_next     = ok_reg;
        hout_next   = hout_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = key_reg;
        stat        = '0;
        unique case (cmd.op)
            sdq_pkg::OP_LOAD: begin
                idx_next   = '0;
                found_next = 1'b0;
                ok_next    = 1'b0;
                hout_next  = '0;
                pos_next   = '0;
            end
            sdq_pkg::OP_SEARCH: begin
                stat.cmd_done = 1'b1;
                stat.scan_done = 1'b1;
                case (op_reg) inside
                    sdq_pkg::CMD_ADD_TAIL: begin
                        if (count_reg < DEPTH_C) begin
                            wr_en      = 1'b1;
                            wr_addr    = AW'(count_reg);
                            count_next = count_reg + 1'b1;
                            ok_next    = 1'b1;
                        end
                    end
                    sdq_pkg::CMD_ADD_HEAD: begin
                        if (count_reg < DEPTH_C) begin
                            ok_next  = 1'b1;
                            idx_next = count_reg;
                            if (cursor_reg != '0 && cursor_reg < CURSOR_MAX) begin
                                cursor_next = cursor_reg + 1'b1;
                            end
                            stat.cmd_done   = 1'b0;
                            stat.shift_done = 1'b1;
                        end
                    end
                    sdq_pkg::CMD_CLEAR: begin
                        count_next  = '0;
                        cursor_next = '0;
                        ok_next     = 1'b1;
                    end
                    sdq_pkg::CMD_REMOVE, sdq_pkg::CMD_CONTAINS: begin
                        // One entry per cycle; read data is registered, so each compare sees the entry read at idx-1.
                        stat.scan_done = 1'b0;
                        if (rd_pend_reg && rd_data_reg == key_reg && !found_reg) begin
                            found_next = 1'b1;
                            pos_next   = idx_reg - 1'b1;
                        end
                        if (found_next || (idx_reg >= count_reg && !rd_pend_reg)) begin
                            stat.scan_done = 1'b1;
                            if (found_next) begin
                                ok_next = 1'b1;
                                if (op_reg == sdq_pkg::CMD_CONTAINS) begin
                                    cursor_next = KW'(pos_next);
                                end else begin
                                    if (cursor_reg != '0 && KW'(pos_next) < cursor_reg) begin
                                        cursor_next = cursor_reg - 1'b1;
                                    end
                                    stat.cmd_done = 1'b0;
                                    idx_next      = pos_next;
                                end
                            end
                        end else if (idx_reg < count_reg) begin
                            rd_en    = 1'b1;
                            rd_addr  = AW'(idx_reg);
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    sdq_pkg::CMD_POP_HEAD, sdq_pkg::CMD_POP_TAIL,
                    sdq_pkg::CMD_FIRST, sdq_pkg::CMD_NEXT: begin
                        // Issue one read, then take its data in the next cycle.
                        stat.scan_done = rd_pend_reg;
                        if (!rd_pend_reg) begin
                            rd_en = 1'b1;
                            case (op_reg)
                                sdq_pkg::CMD_POP_TAIL: rd_addr = AW'(count_reg - 1'b1);
                                sdq_pkg::CMD_NEXT:     rd_addr = AW'(cursor_reg);
                                default:               rd_addr = '0;
                            endcase
                            if (op_reg == sdq_pkg::CMD_FIRST && count_reg == '0) begin
                                cursor_next    = '0;
                                stat.scan_done = 1'b1;
                            end else if (op_reg != sdq_pkg::CMD_NEXT && count_reg == '0) begin
                                stat.scan_done = 1'b1;
                            end else if (op_reg == sdq_pkg::CMD_NEXT
                                         && !(cursor_reg < KW'(count_reg))) begin
                                stat.scan_done = 1'b1;
                            end
                        end else begin
                            ok_next   = 1'b1;
                            hout_next = rd_data_reg;
                            case (op_reg)
                                sdq_pkg::CMD_POP_HEAD: begin
                                    if (cursor_reg != '0) begin
                                        cursor_next = cursor_reg - 1'b1;
                                    end
                                    stat.cmd_done = 1'b0;
                                    idx_next      = '0;
                                end
                                sdq_pkg::CMD_POP_TAIL: begin
                                    if (cursor_reg != '0
                                        && KW'(count_reg - 1'b1) == cursor_reg) begin
                                        cursor_next = cursor_reg - 1'b1;
                                    end
                                    count_next = count_reg - 1'b1;
                                end
                                sdq_pkg::CMD_FIRST: cursor_next = KW'(1);
                                default:            cursor_next = cursor_reg + 1'b1;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            sdq_pkg::OP_SHDN: begin
                // Move entry idx+1 to idx; read first, write the next cycle.
                if (!rd_pend_reg) begin
                    if (idx_reg + 1'b1 >= count_reg) begin
                        stat.shift_done = 1'b1;
                        count_next      = count_reg - 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(idx_reg + 1'b1);
                    end
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(idx_reg);
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg + 1'b1;
                end
            end
            sdq_pkg::OP_SHUP: begin
                // Move entry idx-1 to idx downward from the tail, then write head.
                if (!rd_pend_reg) begin
                    if (idx_reg == '0) begin
                        wr_en           = 1'b1;
                        wr_addr         = '0;
                        wr_data         = key_reg;
                        count_next      = count_reg + 1'b1;
                        stat.shift_done = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(idx_reg - 1'b1);
                    end
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(idx_reg);
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cursor_reg  <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            rd_pend_reg <= rd_en;
            if (cmd.op == sdq_pkg::OP_FINISH) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        ok_reg    <= ok_next;
        hout_reg  <= hout_next;
        if (cmd.op == sdq_pkg::OP_LOAD) begin
            op_reg  <= s_command;
            key_reg <= key_in;
        end
    end

    // Result register, loaded when the command finishes.
    logic                           res_ok_reg;
    logic [sdq_pkg::HOUT_W-1:0]     res_hout_reg;
    logic [sdq_pkg::COUNT_W-1:0]    res_count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.op == sdq_pkg::OP_FINISH) begin
            res_ok_reg    <= ok_reg;
            res_hout_reg  <= ok_reg ? sdq_pkg::HOUT_W'({{64{1'b0}}, hout_reg}) : '0;
            res_count_reg <= sdq_pkg::COUNT_W'(count_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = res_ok_reg;
    assign m_handle_out = res_hout_reg;
    assign m_count      = res_count_reg;
    assign m_is_empty   = (res_count_reg == '0);

endmodule

### rtl/core/searchable_deque_with_cursor_unit.sv
// Top level of the searchable deque with cursor: controller plus datapath.
//
//  channel | ports                                      | dir
//  input   | s_valid s_ready s_command s_handle          | in
//  result  | m_valid m_ready m_ok m_handle_out m_count m_is_empty | out
//
// Add tail, clear, unknown commands, refused adds and empty pops neither scan nor move entries;
// pop head, pop tail, first and next read one entry; contains and remove scan the entries,
// and add at head, pop head and a remove hit then move the entries.
// A search compares one entry per cycle; a move reads each entry and then writes it one place over.
// aresetn is synchronous, active low; it empties the store and resets the cursor.
// A result waiting in the output register holds s_ready low until it is taken.
module searchable_deque_with_cursor_unit #(
    parameter int DEPTH        = 64,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_command,
    input  logic [31:0] s_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [31:0] m_handle_out,
    output logic [6:0]  m_count,
    output logic        m_is_empty
);

    sdq_pkg::sdq_cmd_t  cmd;
    sdq_pkg::sdq_stat_t stat;

    sdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sdq_datapath #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_command    (s_command),
        .s_handle     (s_handle),
        .cmd          (cmd),
        .stat         (stat),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_ok         (m_ok),
        .m_handle_out (m_handle_out),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty)
    );

endmodule
